[design/ffst_pkg.sv]
// shared types, codes and constants for the free-list slot table
package ffst_pkg;

   localparam int FFL_ENTRIES     = 1024;
   localparam int FFL_TYPE_BITS   = 4;

   localparam int SLOT_FIELD_BITS = 10;
   localparam int HANDLE_BITS     = 17;
   localparam int OFFSET_BITS     = 16;
   localparam int TYPE_FIELD_BITS = 4;
   localparam int TYPE_EXT_BITS   = 16;
   localparam int RANGE_BITS      = 18;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLOSE   = 2'd2,
      OP_LOOKUP  = 2'd3
   } op_code_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_FULL       = 3'd1,
      STATUS_BAD_HANDLE = 3'd2,
      STATUS_NOT_SOCKET = 3'd3,
      STATUS_WRONG_TYPE = 3'd4
   } status_code_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HANDLE_OFFSET = 1'b0,
      CSR_SOCKET_TYPE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_code_type                operation;
      logic [HANDLE_BITS-1:0]     handle_number;
      logic [SLOT_FIELD_BITS-1:0] slot_index;
      logic [TYPE_FIELD_BITS-1:0] object_type;
   } req_type;

   typedef struct packed {
      status_code_type            status;
      logic [SLOT_FIELD_BITS-1:0] result_slot;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctrl_status_type;

endpackage

[design/ffst_ctrl.sv]
// controller: clearing pass, request accept and response handshake
module ffst_ctrl
   import ffst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type stat,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.clear_en = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.commit   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/ffst_datapath.sv]
// datapath: slot and link memories, free list pointers, config and response registers
module ffst_datapath
   import ffst_pkg::*;
#(
   parameter int ENTRIES   = FFL_ENTRIES,
   parameter int TYPE_BITS = FFL_TYPE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  req_type                  req_data,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   input  ctrl_cmd_type             cmd,
   output ctrl_status_type          stat,
   output rsp_type                  rsp_data
);

   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT    = SLOT_BITS'(ENTRIES - 1);
   localparam logic [RANGE_BITS-1:0] ENTRIES_WIDE = RANGE_BITS'(ENTRIES);

   // link store and slot store (occupied flag on top of the type)
   logic [SLOT_BITS-1:0] next_mem [ENTRIES];
   logic [TYPE_BITS:0]   slot_mem [ENTRIES];

   logic [OFFSET_BITS-1:0]     offset_ff, offset_in;
   logic [TYPE_FIELD_BITS-1:0] socket_ff, socket_in;
   logic [SLOT_BITS-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [SLOT_BITS-1:0]       head_ff, head_in;
   logic [SLOT_BITS-1:0]       tail_ff, tail_in;
   logic                       empty_ff, empty_in;

   op_code_type          op_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 in_range_ff;
   logic [TYPE_BITS-1:0] otype_ff;
   logic [SLOT_BITS-1:0] next_rd_ff;
   logic [TYPE_BITS:0]   slot_rd_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [RANGE_BITS-1:0]    handle_wide;
   logic [RANGE_BITS-1:0]    raw_wide;
   logic                     handle_ok;
   logic                     raw_ok;
   logic [SLOT_BITS-1:0]     idx_sel;
   logic                     in_range_sel;
   logic [TYPE_EXT_BITS-1:0] otype_wide;
   logic [TYPE_EXT_BITS-1:0] socket_wide;
   logic [TYPE_BITS-1:0]     otype_sel;
   logic [TYPE_BITS-1:0]     socket_code;

   logic                 alloc_ok;
   logic                 give_ok;
   status_code_type      status;
   logic [SLOT_BITS-1:0] slot;
   logic [RANGE_BITS-1:0] slot_wide;

   logic                 next_we;
   logic [SLOT_BITS-1:0] next_wa;
   logic [SLOT_BITS-1:0] next_wd;
   logic                 slot_we;
   logic [SLOT_BITS-1:0] slot_wa;
   logic [TYPE_BITS:0]   slot_wd;
   logic [SLOT_BITS-1:0] clr_next;

   // configuration registers
   always_comb begin
      offset_in = offset_ff;
      socket_in = socket_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HANDLE_OFFSET: offset_in = csr_data;
            CSR_SOCKET_TYPE:   socket_in = csr_data[TYPE_FIELD_BITS-1:0];
            default:           offset_in = offset_ff;
         endcase
      end
   end

   // index decode on the accept side
   always_comb begin
      handle_wide  = RANGE_BITS'(req_data.handle_number) - RANGE_BITS'(offset_ff);
      raw_wide     = RANGE_BITS'(req_data.slot_index);
      handle_ok    = !handle_wide[RANGE_BITS-1] && (handle_wide < ENTRIES_WIDE);
      raw_ok       = (raw_wide < ENTRIES_WIDE);
      if (req_data.operation == OP_RELEASE) begin
         idx_sel      = raw_wide[SLOT_BITS-1:0];
         in_range_sel = raw_ok;
      end else begin
         idx_sel      = handle_wide[SLOT_BITS-1:0];
         in_range_sel = handle_ok;
      end
      otype_wide  = TYPE_EXT_BITS'(req_data.object_type);
      socket_wide = TYPE_EXT_BITS'(socket_ff);
      otype_sel   = otype_wide[TYPE_BITS-1:0];
      socket_code = socket_wide[TYPE_BITS-1:0];
   end

   // request capture and memory reads
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_data.operation;
         idx_ff      <= idx_sel;
         in_range_ff <= in_range_sel;
         otype_ff    <= otype_sel;
         next_rd_ff  <= next_mem[head_ff];
         slot_rd_ff  <= slot_mem[idx_sel];
      end
   end

   // decision on the read data
   always_comb begin
      status   = STATUS_BAD_HANDLE;
      slot     = '0;
      alloc_ok = 1'b0;
      give_ok  = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (empty_ff) begin
               status = STATUS_FULL;
            end else begin
               status   = STATUS_OK;
               slot     = head_ff;
               alloc_ok = 1'b1;
            end
         end
         OP_RELEASE, OP_CLOSE: begin
            if (in_range_ff && slot_rd_ff[TYPE_BITS]) begin
               status  = STATUS_OK;
               slot    = idx_ff;
               give_ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (in_range_ff && slot_rd_ff[TYPE_BITS]) begin
               if (slot_rd_ff[TYPE_BITS-1:0] != otype_ff) begin
                  status = (otype_ff == socket_code) ? STATUS_NOT_SOCKET : STATUS_WRONG_TYPE;
               end else begin
                  status = STATUS_OK;
                  slot   = idx_ff;
               end
            end
         end
         default: status = STATUS_BAD_HANDLE;
      endcase
      slot_wide          = RANGE_BITS'(slot);
      rsp_in.status      = status;
      rsp_in.result_slot = slot_wide[SLOT_FIELD_BITS-1:0];
   end

   // free list pointers
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      if (cmd.commit && alloc_ok) begin
         if (head_ff == tail_ff) begin
            empty_in = 1'b1;
         end else begin
            head_in = next_rd_ff;
         end
      end
      if (cmd.commit && give_ok) begin
         if (empty_ff) begin
            head_in  = idx_ff;
            empty_in = 1'b0;
         end
         tail_in = idx_ff;
      end
   end

   // memory write ports, shared with the clearing pass
   always_comb begin
      clr_next   = (clr_cnt_ff == LAST_SLOT) ? '0 : clr_cnt_ff + 1'b1;
      clr_cnt_in = cmd.clear_en ? clr_next : clr_cnt_ff;
      stat.clear_last = (clr_cnt_ff == LAST_SLOT);
      if (cmd.clear_en) begin
         next_we = 1'b1;
         next_wa = clr_cnt_ff;
         next_wd = clr_next;
         slot_we = 1'b1;
         slot_wa = clr_cnt_ff;
         slot_wd = '0;
      end else begin
         next_we = cmd.commit && give_ok && !empty_ff;
         next_wa = tail_ff;
         next_wd = idx_ff;
         slot_we = cmd.commit && (alloc_ok || give_ok);
         slot_wa = alloc_ok ? head_ff : idx_ff;
         slot_wd = {alloc_ok, otype_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         socket_ff  <= '0;
         clr_cnt_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= LAST_SLOT;
         empty_ff   <= 1'b0;
      end else begin
         offset_ff  <= offset_in;
         socket_ff  <= socket_in;
         clr_cnt_ff <= clr_cnt_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         empty_ff   <= empty_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[design/fifo_free_list_slot_table.sv]
// top level of the free-list slot table: controller plus datapath
//
//   channel   ports                          direction
//   request   req_valid req_ready req_data   in
//   response  rsp_valid rsp_ready rsp_data   out
//   config    csr_wr_en csr_index csr_data   in
//
// each request reads the memories at accept, then decides and writes back in the execute state
// one request is in flight at a time: req_ready stays low until the previous one commits
// after reset a clearing pass over all ENTRIES slots rebuilds the links and occupied flags,
// req_ready stays low during it; config writes are taken at any time
// a response held by rsp_ready low stalls the following request in its execute state
module fifo_free_list_slot_table
   import ffst_pkg::*;
#(
   parameter int ENTRIES   = FFL_ENTRIES,
   parameter int TYPE_BITS = FFL_TYPE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type stat;

   ffst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffst_datapath #(
      .ENTRIES   (ENTRIES),
      .TYPE_BITS (TYPE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

[design/ffst_checker.sv]
// port-level checks for the free-list slot table, bound to the top level
module ffst_checker
   import ffst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // no error response carries a slot
   a_slot_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.result_slot == '0)
      else $error("error response with nonzero slot");

   // clearing pass blocks requests and no response is pending after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

endmodule

bind fifo_free_list_slot_table ffst_checker u_ffst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[dv/tb.sv]
// testbench for the free-list slot table: request tracker, drivers and stimulus
module tb;
   import ffst_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned DRAIN_CYCLES = 4;

   class slot_table_tracker;
      logic [OFFSET_BITS-1:0]     handle_offset;
      logic [TYPE_FIELD_BITS-1:0] socket_type;
      logic [SLOT_FIELD_BITS-1:0] next_free [FFL_ENTRIES];
      logic [SLOT_FIELD_BITS-1:0] free_head;
      logic [SLOT_FIELD_BITS-1:0] free_tail;
      bit                         list_empty;
      bit                         in_use [FFL_ENTRIES];
      logic [TYPE_FIELD_BITS-1:0] slot_kind [FFL_ENTRIES];
      rsp_type                    awaited_rsps [$];
      int unsigned                occupied_count;
      int unsigned                errors;
      int unsigned                checked;
      int unsigned                status_seen [5];

      function new();
         for (int i = 0; i < FFL_ENTRIES; i++) begin
            next_free[i] = SLOT_FIELD_BITS'((i + 1) % FFL_ENTRIES);
            in_use[i]    = 1'b0;
            slot_kind[i] = '0;
         end
         free_head      = '0;
         free_tail      = SLOT_FIELD_BITS'(FFL_ENTRIES - 1);
         list_empty     = 1'b0;
         handle_offset  = '0;
         socket_type    = '0;
         occupied_count = 0;
         errors         = 0;
         checked        = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_HANDLE_OFFSET: handle_offset = value[OFFSET_BITS-1:0];
            CSR_SOCKET_TYPE:   socket_type   = value[TYPE_FIELD_BITS-1:0];
            default: ;
         endcase
      endfunction

      // occupied slot goes back to the tail of the free list
      function status_code_type give_back(logic [SLOT_FIELD_BITS-1:0] slot);
         if (!in_use[slot]) return STATUS_BAD_HANDLE;
         in_use[slot] = 1'b0;
         occupied_count--;
         if (list_empty) begin
            free_head  = slot;
            list_empty = 1'b0;
         end else begin
            next_free[free_tail] = slot;
         end
         free_tail = slot;
         return STATUS_OK;
      endfunction

      function void note_request(req_type item);
         status_code_type            st;
         logic [SLOT_FIELD_BITS-1:0] slot;
         int                         diff;
         bit                         in_range;
         rsp_type                    want;
         st       = STATUS_BAD_HANDLE;
         slot     = '0;
         diff     = int'(item.handle_number) - int'(handle_offset);
         in_range = (diff >= 0) && (diff < FFL_ENTRIES);
         case (item.operation)
            OP_ALLOC: begin
               if (list_empty) begin
                  st = STATUS_FULL;
               end else begin
                  slot = free_head;
                  if (slot == free_tail) list_empty = 1'b1;
                  else free_head = next_free[slot];
                  in_use[slot]    = 1'b1;
                  slot_kind[slot] = item.object_type;
                  occupied_count++;
                  st = STATUS_OK;
               end
            end
            OP_RELEASE: begin
               if (int'(item.slot_index) < FFL_ENTRIES) begin
                  slot = item.slot_index;
                  st   = give_back(slot);
               end
            end
            OP_CLOSE: begin
               if (in_range) begin
                  slot = SLOT_FIELD_BITS'(diff);
                  st   = give_back(slot);
               end
            end
            default: begin
               if (in_range) begin
                  slot = SLOT_FIELD_BITS'(diff);
                  if (!in_use[slot]) st = STATUS_BAD_HANDLE;
                  else if (slot_kind[slot] != item.object_type)
                     st = (item.object_type == socket_type) ? STATUS_NOT_SOCKET
                                                            : STATUS_WRONG_TYPE;
                  else st = STATUS_OK;
               end
            end
         endcase
         want.status      = st;
         want.result_slot = (st == STATUS_OK) ? slot : '0;
         status_seen[int'(st)]++;
         awaited_rsps.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsps.size() == 0) begin
            errors++;
            $display("%0t: response with none awaited: status %0d slot %0d",
                     $time, got.status, got.result_slot);
            return;
         end
         want = awaited_rsps.pop_front();
         checked++;
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
         end
         if (got.result_slot !== want.result_slot) begin
            errors++;
            $display("%0t: result_slot mismatch: expected %0d actual %0d",
                     $time, want.result_slot, got.result_slot);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_wr_en;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   slot_table_tracker tracker;
   bit                steady;
   bit                hold_off_req;
   int unsigned       cycle_count;
   int unsigned       sent;
   int unsigned       settings_used;

   fifo_free_list_slot_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_request(req_data);
         if (rsp_valid && rsp_ready) tracker.check_response(rsp_data);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side: random stalls, plus one long hold-off on demand
   initial begin : response_side
      int unsigned stall_left;
      bit          hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (hold_off_req && !hold_taken) begin
               hold_taken = 1'b1;
               stall_left = LONG_HOLD;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_req(op_code_type op, logic [HANDLE_BITS-1:0] h,
                                        logic [SLOT_FIELD_BITS-1:0] s,
                                        logic [TYPE_FIELD_BITS-1:0] t);
      req_type item;
      item.operation     = op;
      item.handle_number = h;
      item.slot_index    = s;
      item.object_type   = t;
      return item;
   endfunction

   function automatic logic [HANDLE_BITS-1:0] handle_of(int slot);
      return HANDLE_BITS'(tracker.handle_offset) + HANDLE_BITS'(slot);
   endfunction

   function automatic int pick_occupied();
      int start;
      if (tracker.occupied_count == 0) return -1;
      start = $urandom_range(0, FFL_ENTRIES - 1);
      for (int i = 0; i < FFL_ENTRIES; i++)
         if (tracker.in_use[(start + i) % FFL_ENTRIES]) return (start + i) % FFL_ENTRIES;
      return -1;
   endfunction

   // holds valid and payload until the request is taken
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      tracker.write_register(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.awaited_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input int unsigned offset, input int unsigned sock);
      wait_drained();
      write_csr(CSR_HANDLE_OFFSET, CSR_DATA_BITS'(offset));
      write_csr(CSR_SOCKET_TYPE, CSR_DATA_BITS'(sock));
      settings_used++;
   endtask

   task automatic issue_mixed(input int unsigned alloc_pct);
      int unsigned                pick;
      int unsigned                pick2;
      int                         slot;
      int unsigned                offset;
      logic [TYPE_FIELD_BITS-1:0] t;
      logic [HANDLE_BITS-1:0]     h;
      pick   = $urandom_range(0, 99);
      pick2  = $urandom_range(0, 99);
      slot   = pick_occupied();
      offset = tracker.handle_offset;
      if (pick < alloc_pct) begin
         send_request(make_req(OP_ALLOC, HANDLE_BITS'($urandom), SLOT_FIELD_BITS'($urandom),
                               TYPE_FIELD_BITS'($urandom)));
      end else if (pick2 < 35 && slot >= 0) begin
         if ($urandom_range(0, 1) == 0)
            send_request(make_req(OP_RELEASE, HANDLE_BITS'($urandom), SLOT_FIELD_BITS'(slot),
                                  TYPE_FIELD_BITS'($urandom)));
         else
            send_request(make_req(OP_CLOSE, handle_of(slot), SLOT_FIELD_BITS'($urandom),
                                  TYPE_FIELD_BITS'($urandom)));
      end else if (pick2 < 65 && slot >= 0) begin
         case ($urandom_range(0, 3))
            0, 1:    t = tracker.slot_kind[slot];
            2:       t = tracker.socket_type;
            default: t = TYPE_FIELD_BITS'($urandom);
         endcase
         send_request(make_req(OP_LOOKUP, handle_of(slot), SLOT_FIELD_BITS'($urandom), t));
      end else if (pick2 < 80) begin
         slot = $urandom_range(0, FFL_ENTRIES - 1);
         send_request(make_req(op_code_type'($urandom_range(1, 3)), handle_of(slot),
                               SLOT_FIELD_BITS'(slot), TYPE_FIELD_BITS'($urandom)));
      end else if (pick2 < 92) begin
         // handles below the offset, past the table, and the top value
         case ($urandom_range(0, 2))
            0:       h = (offset == 0) ? '0 : HANDLE_BITS'($urandom_range(0, offset - 1));
            1:       h = HANDLE_BITS'($urandom_range(offset + FFL_ENTRIES, 17'h1FFFF));
            default: h = '1;
         endcase
         send_request(make_req(($urandom_range(0, 1) == 0) ? OP_CLOSE : OP_LOOKUP, h,
                               SLOT_FIELD_BITS'($urandom), TYPE_FIELD_BITS'($urandom)));
      end else begin
         send_request(make_req(op_code_type'($urandom_range(0, 3)), HANDLE_BITS'($urandom),
                               SLOT_FIELD_BITS'($urandom), TYPE_FIELD_BITS'($urandom)));
      end
   endtask

   task automatic run_mix(input int unsigned count, input int unsigned alloc_pct,
                          input bit vary_idle);
      for (int unsigned k = 0; k < count; k++) begin
         if (vary_idle && k % 40 == 0) steady = ($urandom_range(0, 4) == 0);
         issue_mixed(alloc_pct);
      end
   endtask

   // allocate, with lookups of occupied slots mixed in, until the free list runs dry, then three allocations past full
   task automatic fill_table();
      int slot;
      while (tracker.occupied_count < FFL_ENTRIES) begin
         slot = pick_occupied();
         if (slot >= 0 && $urandom_range(0, 7) == 0)
            send_request(make_req(OP_LOOKUP, handle_of(slot), SLOT_FIELD_BITS'($urandom),
                                  tracker.slot_kind[slot]));
         else
            send_request(make_req(OP_ALLOC, HANDLE_BITS'($urandom), SLOT_FIELD_BITS'($urandom),
                                  TYPE_FIELD_BITS'($urandom)));
      end
      repeat (3)
         send_request(make_req(OP_ALLOC, '0, '0, TYPE_FIELD_BITS'($urandom)));
   endtask

   initial begin : stimulus
      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_HANDLE_OFFSET;
      csr_data      = '0;
      steady        = 1'b0;
      hold_off_req  = 1'b0;
      sent          = 0;
      settings_used = 0;
      tracker       = new();
      reset         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      apply_settings(100, 15);
      send_request(make_req(OP_LOOKUP, 17'd100, 10'd0, 4'd0));
      send_request(make_req(OP_RELEASE, 17'd0, 10'd0, 4'd0));
      send_request(make_req(OP_CLOSE, 17'd100, 10'd0, 4'd0));
      send_request(make_req(OP_ALLOC, 17'd0, 10'd0, 4'd15));
      send_request(make_req(OP_ALLOC, 17'd0, 10'd0, 4'd0));
      send_request(make_req(OP_ALLOC, 17'd0, 10'd0, 4'd9));
      send_request(make_req(OP_LOOKUP, 17'd100, 10'd0, 4'd15));
      send_request(make_req(OP_LOOKUP, 17'd101, 10'd0, 4'd15));
      send_request(make_req(OP_LOOKUP, 17'd101, 10'd0, 4'd3));
      send_request(make_req(OP_LOOKUP, 17'd99, 10'd0, 4'd0));
      send_request(make_req(OP_CLOSE, 17'd1124, 10'd0, 4'd0));
      send_request(make_req(OP_LOOKUP, 17'h1FFFF, 10'h3FF, 4'hF));
      send_request(make_req(OP_RELEASE, 17'd0, 10'd1023, 4'd0));
      send_request(make_req(OP_RELEASE, 17'd0, 10'd0, 4'd0));
      send_request(make_req(OP_RELEASE, 17'd0, 10'd0, 4'd0));
      send_request(make_req(OP_CLOSE, 17'd102, 10'd0, 4'd0));
      send_request(make_req(OP_LOOKUP, 17'd102, 10'd0, 4'd9));
      send_request(make_req(OP_ALLOC, 17'd0, 10'd0, 4'hA));
      send_request(make_req(OP_CLOSE, 17'd101, 10'd0, 4'd0));
      send_request(make_req(OP_LOOKUP, 17'd103, 10'd0, 4'hA));

      apply_settings(0, 0);
      run_mix(100, 40, 1'b1);
      wait_drained();
      run_mix(100, 40, 1'b1);

      // response side holds off while requests keep coming
      apply_settings(65535, 15);
      steady       = 1'b1;
      hold_off_req = 1'b1;
      run_mix(40, 40, 1'b0);
      run_mix(160, 35, 1'b1);

      apply_settings($urandom_range(0, 65535), $urandom_range(0, 15));
      run_mix(200, 35, 1'b1);

      apply_settings(64512, 7);
      steady = 1'b0;
      fill_table();
      run_mix(60, 50, 1'b1);

      apply_settings($urandom_range(0, 65535), 0);
      run_mix(200, 10, 1'b1);

      apply_settings(1, $urandom_range(0, 15));
      run_mix(150, 25, 1'b1);

      wait_drained();
      repeat (8) @(negedge clock);
      if (tracker.awaited_rsps.size() != 0) begin
         tracker.errors++;
         $display("%0t: %0d responses never arrived", $time, tracker.awaited_rsps.size());
      end
      $display("%0d requests, %0d responses checked over %0d register settings",
               sent, tracker.checked, settings_used);
      $display("ok %0d, full %0d, bad handle %0d, not socket %0d, wrong type %0d",
               tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
               tracker.status_seen[3], tracker.status_seen[4]);
      if (tracker.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
